>>> rtl/core/signature_record_scanner_assert.svh
// assertion macros used by the scanner port checker
`ifndef SIGNATURE_RECORD_SCANNER_ASSERT_SVH
`define SIGNATURE_RECORD_SCANNER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/srs_pkg.sv
// shared types, constants and crc function of the signature record scanner
package srs_pkg;

  localparam int OFFSET_W = 16;
  localparam int LEN_W    = 16;
  localparam int BYTE_W   = 8;

  localparam logic [LEN_W-1:0]    FIXED_V1_LENGTH  = 16'd768;
  localparam logic [LEN_W-1:0]    ERASED_LENGTH    = 16'hFFFF;
  localparam logic [LEN_W-1:0]    MIN_LENGTH       = 16'd7;
  localparam logic [OFFSET_W-1:0] NOT_FOUND_OFFSET = 16'hFFFF;

  localparam logic [BYTE_W-1:0] MAJOR_V1 = 8'd1;
  localparam logic [BYTE_W-1:0] MAJOR_V2 = 8'd2;

  // byte positions inside a record header
  localparam logic [LEN_W-1:0] IDX_LEN_HI = 16'd3;
  localparam logic [LEN_W-1:0] IDX_LEN_LO = 16'd4;
  localparam logic [LEN_W-1:0] IDX_TYPE   = 16'd5;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_WANTED_TYPE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_START_OFFSET = 3'd4;

  // front to back queue, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef struct packed {
    logic [BYTE_W-1:0]   area_byte;
    logic                area_end;
    logic                is_v1;
    logic                is_old_major;
    logic [OFFSET_W-1:0] offset;
  } srs_entry_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] record_offset;
    logic [LEN_W-1:0]    record_length;
    logic [BYTE_W-1:0]   version_major;
  } srs_result_t;

  // crc-16/xmodem, one byte, msb first
  function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/signature_record_scanner.sv
// top level of the signature record scanner: config registers, front, queue, back
// throughput: one area byte per cycle while the back end is not held by a stalled result, set by the
//   crc and field update of the back end; a deciding byte passes the queue and the result register
//   on its way to the outputs, after any bytes already queued ahead of it (up to 3)
// the 4-entry queue lets input transfers continue while a result waits on out_stall
// reset (synchronous, rst_n low): queue emptied, scan state cleared, both registers zero
module signature_record_scanner (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [srs_pkg::BYTE_W-1:0]     in_area_byte,
  input  logic                           in_area_end,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_found,
  output logic [srs_pkg::OFFSET_W-1:0]   out_record_offset,
  output logic [srs_pkg::LEN_W-1:0]      out_record_length,
  output logic [srs_pkg::BYTE_W-1:0]     out_version_major,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [srs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [srs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import srs_pkg::*;

  logic [BYTE_W-1:0]   wanted_type_r, wanted_type_nxt;
  logic [OFFSET_W-1:0] start_offset_r, start_offset_nxt;
  logic                cfg_wr;

  logic        q_push, q_pop, q_not_empty, q_full;
  srs_entry_t  q_push_data, q_pop_data;
  srs_result_t result;

  // configuration: write completes in the access phase, pready tied high
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    wanted_type_nxt  = wanted_type_r;
    start_offset_nxt = start_offset_r;
    if (cfg_wr) begin
      unique case (cfg_paddr)
        CFG_ADDR_WANTED_TYPE:  wanted_type_nxt  = cfg_pwdata[BYTE_W-1:0];
        CFG_ADDR_START_OFFSET: start_offset_nxt = cfg_pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, unmapped addresses read zero
  always_comb begin
    unique case (cfg_paddr)
      CFG_ADDR_WANTED_TYPE:  cfg_prdata = CFG_DATA_W'(wanted_type_r);
      CFG_ADDR_START_OFFSET: cfg_prdata = CFG_DATA_W'(start_offset_r);
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r  <= '0;
      start_offset_r <= '0;
    end else begin
      wanted_type_r  <= wanted_type_nxt;
      start_offset_r <= start_offset_nxt;
    end
  end

  // front end: area offset tagging and major version class
  srs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_area_byte (in_area_byte),
    .in_area_end  (in_area_end),
    .start_offset (start_offset_r),
    .q_full       (q_full),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  // decoupling queue
  srs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // back end: record walk, crc, decision and result register
  srs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_not_empty),
    .entry       (q_pop_data),
    .pop         (q_pop),
    .wanted_type (wanted_type_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (result)
  );

  assign out_found         = result.found;
  assign out_record_offset = result.record_offset;
  assign out_record_length = result.record_length;
  assign out_version_major = result.version_major;

endmodule

>>> rtl/core/srs_queue.sv
// short fifo between the scanner front end and back end
module srs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  srs_pkg::srs_entry_t push_data,
  input  logic               pop,
  output srs_pkg::srs_entry_t pop_data,
  output logic               not_empty,
  output logic               full
);
  import srs_pkg::*;

  srs_entry_t             slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/srs_front.sv
// front end: accepts area bytes, tags offset and version class, feeds the queue
module srs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srs_pkg::BYTE_W-1:0]   in_area_byte,
  input  logic                         in_area_end,
  input  logic [srs_pkg::OFFSET_W-1:0] start_offset,
  input  logic                         q_full,
  output logic                         push,
  output srs_pkg::srs_entry_t          push_data
);
  import srs_pkg::*;

  logic [OFFSET_W-1:0] area_position_r, area_position_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.area_byte    = in_area_byte;
    push_data.area_end     = in_area_end;
    push_data.is_v1        = (in_area_byte == MAJOR_V1);
    push_data.is_old_major = (in_area_byte == MAJOR_V1) || (in_area_byte == MAJOR_V2);
    push_data.offset       = start_offset + area_position_r;

    area_position_nxt = area_position_r;
    if (push) begin
      area_position_nxt = in_area_end ? '0 : area_position_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_position_r <= '0;
    end else begin
      area_position_r <= area_position_nxt;
    end
  end

endmodule

>>> rtl/core/srs_back.sv
// back end: per-byte record walk, crc check and result register
module srs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  srs_pkg::srs_entry_t        entry,
  output logic                       pop,
  input  logic [srs_pkg::BYTE_W-1:0] wanted_type,
  output logic                       out_valid,
  input  logic                       out_stall,
  output srs_pkg::srs_result_t       out_result
);
  import srs_pkg::*;

  logic [LEN_W-1:0]    byte_idx_r, byte_idx_nxt;
  logic [LEN_W-1:0]    size_r, size_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [OFFSET_W-1:0] start_r, start_nxt;
  logic [BYTE_W-1:0]   major_r, major_nxt;
  logic [BYTE_W-1:0]   type_r, type_nxt;
  logic [BYTE_W-1:0]   trail_r, trail_nxt;
  logic                decided_r, decided_nxt;
  logic                out_valid_r, out_valid_nxt;
  srs_result_t         out_res_r, out_res_nxt;

  logic [LEN_W:0]      idx_p1, idx_p2;
  logic                first, bad, hit, emit;
  logic [BYTE_W-1:0]   b;

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  always_comb begin
    byte_idx_nxt = byte_idx_r;
    size_nxt     = size_r;
    crc_nxt      = crc_r;
    start_nxt    = start_r;
    major_nxt    = major_r;
    type_nxt     = type_r;
    trail_nxt    = trail_r;
    decided_nxt  = decided_r;
    bad          = 1'b0;
    hit          = 1'b0;
    emit         = 1'b0;
    b            = entry.area_byte;
    first        = (byte_idx_r == '0);
    idx_p1       = {1'b0, byte_idx_r} + (LEN_W+1)'(1);
    idx_p2       = {1'b0, byte_idx_r} + (LEN_W+1)'(2);

    pop = q_valid && (!out_valid_r || !out_stall);

    if (pop) begin
      if (!decided_r) begin
        // header of a new record
        if (first) begin
          start_nxt = entry.offset;
          major_nxt = b;
          crc_nxt   = '0;
          type_nxt  = '0;
          size_nxt  = entry.is_v1 ? FIXED_V1_LENGTH : '0;
          if (entry.is_old_major && (wanted_type != '0)) begin
            bad = 1'b1;
          end
        end
        if ((major_nxt != MAJOR_V1) && (byte_idx_r == IDX_LEN_HI)) begin
          size_nxt = {b, 8'h00};
        end
        if ((major_nxt != MAJOR_V1) && (byte_idx_r == IDX_LEN_LO)) begin
          size_nxt = size_nxt | {8'h00, b};
          if ((size_nxt == ERASED_LENGTH) || (size_nxt < MIN_LENGTH)) begin
            bad = 1'b1;
          end
        end
        if (byte_idx_r == IDX_TYPE) begin
          type_nxt = b;
        end
        // crc covers all but the two trailer bytes
        if ((byte_idx_r < IDX_TYPE) || (idx_p2 < {1'b0, size_nxt})) begin
          crc_nxt = crc16_xmodem_byte(crc_nxt, b);
        end
        if (!bad) begin
          if ((byte_idx_r >= IDX_LEN_LO) && (idx_p2 == {1'b0, size_nxt})) begin
            trail_nxt = b;
          end
          if ((byte_idx_r >= IDX_LEN_LO) && (idx_p1 == {1'b0, size_nxt})) begin
            if ({trail_r, b} != crc_nxt) begin
              bad = 1'b1;
            end else if ((major_nxt == MAJOR_V1) || (major_nxt == MAJOR_V2)) begin
              hit = 1'b1;
            end else if (type_nxt == wanted_type) begin
              hit = 1'b1;
            end else begin
              byte_idx_nxt = '0;
            end
          end else begin
            byte_idx_nxt = idx_p1[LEN_W-1:0];
          end
        end
      end
      emit = bad || hit || (entry.area_end && !decided_r);
      if (bad || hit) begin
        decided_nxt = 1'b1;
      end
      if (entry.area_end) begin
        decided_nxt  = 1'b0;
        byte_idx_nxt = '0;
      end
    end

    out_res_nxt.found         = hit;
    out_res_nxt.record_offset = hit ? start_nxt : NOT_FOUND_OFFSET;
    out_res_nxt.record_length = hit ? size_nxt : '0;
    out_res_nxt.version_major = hit ? major_nxt : '0;

    out_valid_nxt = out_valid_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= '0;
      decided_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      decided_r   <= decided_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    crc_r   <= crc_nxt;
    start_r <= start_nxt;
    major_r <= major_nxt;
    type_r  <= type_nxt;
    trail_r <= trail_nxt;
    if (pop && emit) begin
      out_res_r <= out_res_nxt;
    end
  end

endmodule

>>> rtl/core/srs_checker.sv
// port-level checker of the signature record scanner and its bind
module srs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [15:0] out_record_offset,
  input logic [15:0] out_record_length,
  input logic [7:0]  out_version_major
);
  import srs_pkg::*;

`include "signature_record_scanner_assert.svh"

  // a stalled result holds
  `SRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_found) && $stable(out_record_offset) && $stable(out_record_length) && $stable(out_version_major), "result changed while stalled")

  // not found carries the fixed sentinel values
  `SRS_ASSERT_SAME(a_not_found_fields, out_valid && !out_found, (out_record_offset == NOT_FOUND_OFFSET) && (out_record_length == '0) && (out_version_major == '0), "bad not-found fields")

  // a found record never has an erased or short length
  `SRS_ASSERT_SAME(a_found_length, out_valid && out_found, (out_record_length != ERASED_LENGTH) && (out_record_length >= MIN_LENGTH), "found record with illegal length")

  // version 1 records always have the fixed length
  `SRS_ASSERT_SAME(a_v1_length, out_valid && out_found && (out_version_major == MAJOR_V1), out_record_length == FIXED_V1_LENGTH, "version 1 record with wrong length")

endmodule

bind signature_record_scanner srs_checker u_srs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_found         (out_found),
  .out_record_offset (out_record_offset),
  .out_record_length (out_record_length),
  .out_version_major (out_version_major)
);

>>> verif/signature_record_scanner_check.sv
// checker for the signature record scanner: watches the channels, predicts and compares results
`timescale 1ns / 100ps

module signature_record_scanner_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [srs_pkg::BYTE_W-1:0]     in_area_byte,
  input  logic                           in_area_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_found,
  input  logic [srs_pkg::OFFSET_W-1:0]   out_record_offset,
  input  logic [srs_pkg::LEN_W-1:0]      out_record_length,
  input  logic [srs_pkg::BYTE_W-1:0]     out_version_major,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [srs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                           cfg_pready,
  output int                             fail_count,
  output int                             verdicts_owed
);
  import srs_pkg::*;

  typedef enum logic [1:0] {SCAN_OPEN, SCAN_MISS, SCAN_HIT} verdict_t;

  // register copies
  logic [BYTE_W-1:0]   wanted_type_q;
  logic [OFFSET_W-1:0] start_offset_q;

  // scan state
  logic [OFFSET_W-1:0] area_pos;
  logic [OFFSET_W-1:0] rec_start;
  logic [LEN_W-1:0]    rec_idx;
  logic [LEN_W-1:0]    rec_len;
  logic [15:0]         crc_acc;
  logic [BYTE_W-1:0]   rec_major;
  logic [BYTE_W-1:0]   rec_type;
  logic [BYTE_W-1:0]   trailer_hi;
  logic                decided;

  srs_result_t expected_verdicts[$];
  int          results_seen;

  initial fail_count = 0;

  function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_scan_state();
    area_pos   = '0;
    rec_start  = '0;
    rec_idx    = '0;
    rec_len    = '0;
    crc_acc    = '0;
    rec_major  = '0;
    rec_type   = '0;
    trailer_hi = '0;
    decided    = 1'b0;
  endtask

  task automatic push_verdict(input logic hit);
    srs_result_t r;
    r.found         = hit;
    r.record_offset = hit ? rec_start : NOT_FOUND_OFFSET;
    r.record_length = hit ? rec_len : '0;
    r.version_major = hit ? rec_major : '0;
    expected_verdicts.push_back(r);
  endtask

  task automatic predict_scan_byte(input logic [BYTE_W-1:0] b, input logic last);
    verdict_t    v;
    int          idx;
    logic [15:0] stored;
    v = SCAN_OPEN;
    if (!decided) begin
      idx = rec_idx;
      if (idx == 0) begin
        rec_start = start_offset_q + area_pos;
        rec_major = b;
        crc_acc   = '0;
        rec_type  = '0;
        rec_len   = (b == MAJOR_V1) ? FIXED_V1_LENGTH : '0;
        if ((b == MAJOR_V1 || b == MAJOR_V2) && wanted_type_q != '0) v = SCAN_MISS;
      end
      if (rec_major != MAJOR_V1 && idx == IDX_LEN_HI) rec_len = {b, 8'h00};
      if (rec_major != MAJOR_V1 && idx == IDX_LEN_LO) begin
        rec_len = rec_len | {8'h00, b};
        if (rec_len == ERASED_LENGTH || rec_len < MIN_LENGTH) v = SCAN_MISS;
      end
      if (idx == IDX_TYPE) rec_type = b;
      // crc covers the header and everything up to the trailer
      if (idx < IDX_TYPE || idx + 2 < rec_len) crc_acc = crc_after_byte(crc_acc, b);
      if (v == SCAN_OPEN) begin
        if (idx >= IDX_LEN_LO && idx + 2 == rec_len) trailer_hi = b;
        if (idx >= IDX_LEN_LO && idx + 1 == rec_len) begin
          stored = {trailer_hi, b};
          if (stored != crc_acc) v = SCAN_MISS;
          else if (rec_major == MAJOR_V1 || rec_major == MAJOR_V2) v = SCAN_HIT;
          else if (rec_type == wanted_type_q) v = SCAN_HIT;
          else rec_idx = '0;
        end else begin
          rec_idx = 16'(idx + 1);
        end
      end
    end
    area_pos = area_pos + 1'b1;
    if (v != SCAN_OPEN) begin
      push_verdict(v == SCAN_HIT);
      decided = 1'b1;
    end
    if (last) begin
      if (v == SCAN_OPEN && !decided) push_verdict(1'b0);
      clear_scan_state();
    end
  endtask

  task automatic check_result();
    srs_result_t want;
    results_seen++;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("result %0d not expected: found=%0d offset=%0d length=%0d major=%0d",
                                results_seen, out_found, out_record_offset, out_record_length,
                                out_version_major));
    end else begin
      want = expected_verdicts.pop_front();
      if (out_found !== want.found || out_record_offset !== want.record_offset ||
          out_record_length !== want.record_length || out_version_major !== want.version_major) begin
        report_mismatch($sformatf("result %0d: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
                                  results_seen, out_found, out_record_offset, out_record_length,
                                  out_version_major, want.found, want.record_offset,
                                  want.record_length, want.version_major));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_q  = '0;
      start_offset_q = '0;
      results_seen   = 0;
      clear_scan_state();
      expected_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          CFG_ADDR_WANTED_TYPE:  wanted_type_q  = cfg_pwdata[BYTE_W-1:0];
          CFG_ADDR_START_OFFSET: start_offset_q = cfg_pwdata[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_scan_byte(in_area_byte, in_area_end);
    end
    verdicts_owed = expected_verdicts.size();
  end

endmodule

>>> verif/signature_record_scanner_test.sv
// testbench top of the signature record scanner: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module signature_record_scanner_test;
  import srs_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_area_byte;
  logic                  in_area_end;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_found;
  logic [OFFSET_W-1:0]   out_record_offset;
  logic [LEN_W-1:0]      out_record_length;
  logic [BYTE_W-1:0]     out_version_major;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int verdicts_owed;

  // calm and hold_request are shared between the stimulus and the result sink; sender_gaps is the sender's own
  bit calm;           // no idling on either side near the end of the run
  bit hold_request;   // asks the sink for one long stall
  bit sender_gaps;    // per-area switch for idle gaps on the input side

  logic [BYTE_W-1:0] cur_wanted;   // wanted type currently programmed
  logic [BYTE_W-1:0] area_bytes[$];
  int                random_bytes;
  int                v1_left;

  signature_record_scanner uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_area_byte      (in_area_byte),
    .in_area_end       (in_area_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_record_offset (out_record_offset),
    .out_record_length (out_record_length),
    .out_version_major (out_version_major),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  signature_record_scanner_check chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_area_byte      (in_area_byte),
    .in_area_end       (in_area_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_record_offset (out_record_offset),
    .out_record_length (out_record_length),
    .out_version_major (out_version_major),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_pready        (cfg_pready),
    .fail_count        (fail_count),
    .verdicts_owed     (verdicts_owed)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // stimulus side crc, used only to build well-formed trailers
  function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  // one transfer on the byte channel; valid stays high into the next call
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (sender_gaps && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_area_byte <= b;
    in_area_end  <= last;
    // stall seen right after the edge is the value the edge sampled
    do @(posedge clk); while (in_stall);
    random_bytes++;
  endtask

  // stream the built area, end flag on the last byte
  task automatic send_area();
    int n;
    n = area_bytes.size();
    sender_gaps = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) send_byte(area_bytes[i], i == n - 1);
  endtask

  // drop valid and wait until every owed result has come, plus the queue latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are junk the registers must drop
  task automatic set_config(input logic [BYTE_W-1:0] wanted, input logic [OFFSET_W-1:0] start);
    write_reg(CFG_ADDR_WANTED_TYPE, ($urandom() & 32'hFFFF_FF00) | wanted);
    write_reg(CFG_ADDR_START_OFFSET, ($urandom() & 32'hFFFF_0000) | start);
    cur_wanted = wanted;
  endtask

  // append one record; erased or short lengths get only the header, since the scan stops there
  task automatic add_record(input logic [BYTE_W-1:0] major, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] rtype, input bit bad_crc);
    logic [7:0]  rec[$];
    logic [15:0] rec_len;
    logic [15:0] crc;
    rec.push_back(major);
    rec.push_back(8'($urandom()));
    rec.push_back(8'($urandom()));
    if (major == MAJOR_V1) begin
      rec_len = FIXED_V1_LENGTH;
      rec.push_back(8'($urandom()));
      rec.push_back(8'($urandom()));
    end else begin
      rec_len = len;
      rec.push_back(len[15:8]);
      rec.push_back(len[7:0]);
    end
    if (rec_len == ERASED_LENGTH || rec_len < MIN_LENGTH) begin
      area_bytes = {area_bytes, rec};
      return;
    end
    rec.push_back(rtype);
    while (rec.size() < rec_len - 2) rec.push_back(8'($urandom()));
    crc = '0;
    foreach (rec[i]) crc = xmodem_step(crc, rec[i]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    rec.push_back(crc[15:8]);
    rec.push_back(crc[7:0]);
    area_bytes = {area_bytes, rec};
  endtask

  function automatic logic [BYTE_W-1:0] plain_major();
    return ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(3, 255));
  endfunction

  function automatic logic [LEN_W-1:0] body_length();
    return ($urandom_range(0, 19) == 0) ? 16'($urandom_range(7, 300))
                                        : 16'($urandom_range(7, 40));
  endfunction

  // mostly well-formed areas with random content, some broken ones and noise
  task automatic random_area();
    int pick;
    area_bytes.delete();
    repeat ($urandom_range(1, 3)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_record(plain_major(), body_length(), cur_wanted, 1'b0);
      end else if (pick < 55) begin
        // other type, skipped by the scan
        add_record(plain_major(), body_length(), cur_wanted ^ 8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 65) begin
        add_record(MAJOR_V2, body_length(), 8'($urandom()), 1'b0);
      end else if (pick < 68 && v1_left > 0 && cur_wanted == '0) begin
        v1_left--;
        add_record(MAJOR_V1, '0, 8'($urandom()), $urandom_range(0, 3) == 0);
      end else if (pick < 77) begin
        add_record(plain_major(), body_length(), cur_wanted, 1'b1);
      end else if (pick < 82) begin
        add_record(plain_major(), ERASED_LENGTH, '0, 1'b0);
      end else if (pick < 87) begin
        add_record(plain_major(), 16'($urandom_range(0, 6)), '0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) area_bytes.push_back(8'($urandom()));
      end
    end
    // cut-off record now and then
    if ($urandom_range(0, 4) == 0) area_bytes = area_bytes[0:$urandom_range(0, area_bytes.size() - 1)];
    // bytes after the decision or after the last record
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) area_bytes.push_back(8'($urandom()));
    send_area();
  endtask

  // one-byte areas, one result each, while the sink holds off: the queue fills and stalls input
  task automatic flood_while_held();
    hold_request = 1'b1;
    sender_gaps  = 1'b0;
    repeat (40) send_byte(8'($urandom()), 1'b1);
    settle();
  endtask

  // result sink: random stall bursts, one long hold on request, none when calm
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (int n = 0; n < 150; n++) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // hard stop, far beyond the slowest correct run
  initial begin : watchdog
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    logic [BYTE_W-1:0]   wanted;
    logic [OFFSET_W-1:0] start;

    in_valid     = 1'b0;
    in_area_byte = '0;
    in_area_end  = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    sender_gaps  = 1'b1;
    cur_wanted   = '0;
    v1_left      = 2;
    rst_n        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, registers at their reset values first
    // lone byte, no record before the area end
    area_bytes = {8'h00};
    send_area();
    // version 2 record found, bytes after the decision ignored
    area_bytes.delete();
    add_record(MAJOR_V2, 16'd8, 8'h00, 1'b0);
    area_bytes.push_back(8'hFF);
    area_bytes.push_back(MAJOR_V1);
    send_area();
    // erased length
    area_bytes.delete();
    add_record(8'h03, ERASED_LENGTH, '0, 1'b0);
    send_area();
    // short lengths, both ends of the forbidden range
    area_bytes.delete();
    add_record(8'hFF, 16'd6, '0, 1'b0);
    send_area();
    area_bytes.delete();
    add_record(8'h00, 16'd0, '0, 1'b0);
    send_area();
    // crc mismatch
    area_bytes.delete();
    add_record(8'h05, 16'd9, 8'h00, 1'b1);
    send_area();
    settle();

    // highest type, highest offset: skipped record, then a hit past the offset wrap
    set_config(8'hFF, 16'd65534);
    area_bytes.delete();
    add_record(8'h80, 16'd8, 8'h7F, 1'b0);
    add_record(8'hFF, 16'd8, 8'hFF, 1'b0);
    send_area();
    // old versions while a nonzero type is wanted
    area_bytes = {MAJOR_V1};
    send_area();
    area_bytes = {MAJOR_V2, 8'h00, 8'h00};
    send_area();
    settle();

    // fixed-length version 1 record, then a record cut by the area end
    set_config(8'h00, 16'h1234);
    area_bytes.delete();
    add_record(MAJOR_V1, '0, 8'h00, 1'b0);
    send_area();
    area_bytes.delete();
    add_record(8'h03, 16'd20, 8'h00, 1'b0);
    area_bytes = area_bytes[0:9];
    send_area();
    settle();

    // random part in phases, registers rewritten between phases
    random_bytes = 0;
    phase = 0;
    while (random_bytes < 1000) begin
      case (phase % 4)
        0:       wanted = 8'h00;
        1:       wanted = 8'hFF;
        2:       wanted = 8'h00;
        default: wanted = 8'($urandom());
      endcase
      case (phase % 3)
        0:       start = 16'd0;
        1:       start = 16'd65534;
        default: start = 16'($urandom_range(0, 65534));
      endcase
      set_config(wanted, start);
      if (phase == 1 || phase == 4) flood_while_held();
      phase_end = random_bytes + 160;
      while (random_bytes < phase_end && random_bytes < 1000) begin
        calm = (random_bytes >= 850);
        random_area();
      end
      // sender waits for every owed result before the next setting
      settle();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && verdicts_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> signature_record_scanner.f
+incdir+rtl/core
rtl/core/srs_pkg.sv
rtl/core/srs_queue.sv
rtl/core/srs_front.sv
rtl/core/srs_back.sv
rtl/core/signature_record_scanner.sv
rtl/core/srs_checker.sv
verif/signature_record_scanner_check.sv
verif/signature_record_scanner_test.sv
